// File: rtl/qph_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic probe hash insert package
// Shared widths, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int TABLE_MAX  = 16384;
    localparam int ADDR_W     = $clog2(TABLE_MAX);
    localparam int KEY_W      = 31;
    localparam int SIZE_W     = 15;
    localparam int SLOT_W     = 14;
    localparam int EFF_W      = (SIZE_W > ADDR_W + 1) ? SIZE_W : ADDR_W + 1;
    localparam int BIT_CNT_W  = $clog2(KEY_W);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(11);
    localparam logic [EFF_W-1:0]  SIZE_MIN   = EFF_W'(2);
    localparam logic [EFF_W-1:0]  SIZE_MAX   = EFF_W'(TABLE_MAX);

    typedef struct packed {
        logic clr_step;
        logic div_load;
        logic div_step;
        logic rd;
        logic advance;
        logic hit;
        logic miss;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic slot_free;
        logic probe_last;
    } t_stat;

endpackage

// File: rtl/qph_ctrl.sv
// ----------------------------------------------------------------------------
// Quadratic probe hash insert controller
// Sequences the clearing pass, the key reduction and the probe loop.
// ----------------------------------------------------------------------------
module qph_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    output qph_pkg::t_cmd o_cmd,
    input  qph_pkg::t_stat i_stat
);
    import qph_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;
    logic   accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign o_done = r_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.div_load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.slot_free) begin
                    o_cmd.hit = 1'b1;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.probe_last) begin
                    o_cmd.miss = 1'b1;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("Result strobe lasted more than one cycle.");

    a_done_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_CHK))
        else $error("Result strobe without a preceding probe check.");

    a_accept_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DIV))
        else $error("Accepted transaction did not start the key reduction.");

endmodule

// File: rtl/qph_dpath.sv
// ----------------------------------------------------------------------------
// Quadratic probe hash insert datapath
// Size register, bit-serial key modulo, probe position update and the
// occupancy memory with its clearing counter.
// ----------------------------------------------------------------------------
module qph_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [qph_pkg::SIZE_W-1:0]   i_cfg_table_size,
    input  logic [qph_pkg::KEY_W-1:0]    i_key,
    input  qph_pkg::t_cmd                i_cmd,
    output qph_pkg::t_stat               o_stat,
    output logic [qph_pkg::SLOT_W-1:0]   o_slot_index,
    output logic                         o_placed
);
    import qph_pkg::*;

    logic [SIZE_W-1:0]    r_size;
    logic [EFF_W-1:0]     eff_size;
    logic [ADDR_W-1:0]    limit;

    logic [KEY_W-1:0]     r_key;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [ADDR_W-1:0]    r_rem;
    logic [ADDR_W:0]      trial;
    logic [ADDR_W-1:0]    n_rem;

    logic [ADDR_W-1:0]    r_pos;
    logic [ADDR_W-1:0]    r_inc;
    logic [ADDR_W-1:0]    r_d;
    logic [ADDR_W:0]      pos_sum;
    logic [ADDR_W:0]      inc_sum;
    logic [ADDR_W-1:0]    n_pos;
    logic [ADDR_W-1:0]    n_inc;

    logic                 r_mem [TABLE_MAX];
    logic                 r_rd_data;
    logic [ADDR_W-1:0]    r_clr_addr;

    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_placed;

    always_comb begin
        if (EFF_W'(r_size) < SIZE_MIN) begin
            eff_size = SIZE_MIN;
        end else if (EFF_W'(r_size) > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = EFF_W'(r_size);
        end
    end

    assign limit = ADDR_W'(eff_size >> 1);

    // One restoring division step per cycle, most significant key bit first.
    always_comb begin
        trial = {r_rem, r_key[KEY_W-1]};
        if (EFF_W'(trial) >= eff_size) begin
            n_rem = ADDR_W'(EFF_W'(trial) - eff_size);
        end else begin
            n_rem = trial[ADDR_W-1:0];
        end
    end

    // Successive squares differ by odd numbers, so the probe position and its
    // increment each need only an add and a single conditional subtract.
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_inc};
        inc_sum = {1'b0, r_inc} + (ADDR_W + 1)'(2);
        if (EFF_W'(pos_sum) >= eff_size) begin
            n_pos = ADDR_W'(EFF_W'(pos_sum) - eff_size);
        end else begin
            n_pos = pos_sum[ADDR_W-1:0];
        end
        if (EFF_W'(inc_sum) >= eff_size) begin
            n_inc = ADDR_W'(EFF_W'(inc_sum) - eff_size);
        end else begin
            n_inc = inc_sum[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_RESET;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_table_size;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_key     <= i_key;
            r_rem     <= '0;
            r_bit_cnt <= BIT_CNT_W'(KEY_W - 1);
        end else if (i_cmd.div_step) begin
            r_key     <= r_key << 1;
            r_rem     <= n_rem;
            r_bit_cnt <= r_bit_cnt - BIT_CNT_W'(1);
        end
        if (i_cmd.div_step && o_stat.div_last) begin
            r_pos <= n_rem;
            r_inc <= ADDR_W'(1);
            r_d   <= '0;
        end else if (i_cmd.advance) begin
            r_pos <= n_pos;
            r_inc <= n_inc;
            r_d   <= r_d + ADDR_W'(1);
        end
        if (i_cmd.hit) begin
            r_out_slot   <= SLOT_W'(r_pos);
            r_out_placed <= 1'b1;
        end else if (i_cmd.miss) begin
            r_out_slot   <= '0;
            r_out_placed <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.hit) begin
            r_mem[r_pos] <= 1'b1;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_pos];
        end
    end

    assign o_stat.clr_last   = (r_clr_addr == ADDR_W'(TABLE_MAX - 1));
    assign o_stat.div_last   = (r_bit_cnt == '0);
    assign o_stat.slot_free  = !r_rd_data;
    assign o_stat.probe_last = (r_d == limit);

    assign o_slot_index = r_out_slot;
    assign o_placed     = r_out_placed;

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit |-> (EFF_W'(r_pos) < eff_size))
        else $error("Selected slot lies outside the table.");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (EFF_W'(r_rem) < eff_size))
        else $error("Partial remainder reached the table size.");

    a_probe_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_d != limit))
        else $error("Probe sequence ran past half the table size.");

endmodule

// File: rtl/quadratic_probe_hash_insert_core.sv
// ----------------------------------------------------------------------------
// Quadratic probe hash insert core
// Inserts keys into an occupancy table by open addressing with quadratic
// probing and reports the slot taken or a failure.
//
// A transaction is accepted on a clock edge with i_start high and o_busy low.
// The key is reduced modulo the effective table size one bit per cycle.
// Each probe is a registered read of the occupancy memory followed by a
// check. o_done rises with the registered result and marks o_slot_index
// and o_placed for exactly one cycle; the number of probes k runs from 1
// to size/2 + 1.
// o_busy drops as o_done rises, so one transaction is in flight at a time
// and the next one can be accepted at the edge that takes the result.
// The receiver cannot stall the result.
// The table size register is written through i_cfg_valid/o_cfg_ready and
// should only change while the core is idle.
// After reset the core sweeps the occupancy memory clear, one slot per
// cycle, holding o_busy high throughout; configuration writes are
// taken during that pass. The size register resets to 11.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_insert_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [qph_pkg::KEY_W-1:0]   i_key,
    output logic                        o_done,
    output logic [qph_pkg::SLOT_W-1:0]  o_slot_index,
    output logic                        o_placed,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [qph_pkg::SIZE_W-1:0]  i_cfg_table_size
);
    import qph_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    qph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    qph_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_table_size (i_cfg_table_size),
        .i_key            (i_key),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_slot_index     (o_slot_index),
        .o_placed         (o_placed)
    );

endmodule
